// ===== hdl/stt_pkg.sv =====
// Shared types, token codes, character constants and lookup functions of the tokenizer.
package stt_pkg;

   // Keyword prefix storage: bytes held per word, byte i at bits 8i.
   localparam int KEYWORD_LEN  = 5;
   localparam int PREFIX_W     = 8 * KEYWORD_LEN;
   localparam int KW_W         = 40;               // widest keyword is five bytes
   localparam int NUM_KW       = 8;
   localparam int WORD_CNT_W   = 3;
   localparam logic [WORD_CNT_W-1:0] WORD_CNT_MAX = 3'd7;

   // Result queue sizing.
   localparam int MAX_RESULTS  = 3;
   localparam int RES_IDX_W    = $clog2(MAX_RESULTS + 1);
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   // Token codes.
   localparam logic [5:0] TOK_NUMBER  = 6'd0;
   localparam logic [5:0] TOK_WORD    = 6'd1;
   localparam logic [5:0] TOK_TEXT    = 6'd2;
   localparam logic [5:0] TOK_KW_BASE = 6'd3;
   localparam logic [5:0] TOK_PLUS    = 6'd11;
   localparam logic [5:0] TOK_MINUS   = 6'd12;
   localparam logic [5:0] TOK_STAR    = 6'd13;
   localparam logic [5:0] TOK_SLASH   = 6'd14;
   localparam logic [5:0] TOK_LPAREN  = 6'd15;
   localparam logic [5:0] TOK_RPAREN  = 6'd16;
   localparam logic [5:0] TOK_LBRACK  = 6'd17;
   localparam logic [5:0] TOK_RBRACK  = 6'd18;
   localparam logic [5:0] TOK_LBRACE  = 6'd19;
   localparam logic [5:0] TOK_RBRACE  = 6'd20;
   localparam logic [5:0] TOK_ASSIGN  = 6'd21;
   localparam logic [5:0] TOK_LT      = 6'd22;
   localparam logic [5:0] TOK_GT      = 6'd23;
   localparam logic [5:0] TOK_COMMA   = 6'd24;
   localparam logic [5:0] TOK_NOT     = 6'd25;
   localparam logic [5:0] TOK_AMP     = 6'd26;
   localparam logic [5:0] TOK_BAR     = 6'd27;
   localparam logic [5:0] TOK_EQ      = 6'd28;
   localparam logic [5:0] TOK_NE      = 6'd29;
   localparam logic [5:0] TOK_LE      = 6'd30;
   localparam logic [5:0] TOK_GE      = 6'd31;
   localparam logic [5:0] TOK_LAND    = 6'd32;
   localparam logic [5:0] TOK_LOR     = 6'd33;
   localparam logic [5:0] TOK_SEMI    = 6'd34;
   localparam logic [5:0] OP_NONE     = 6'd63;   // no operator matches

   // Characters.
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BSLASH = "\\";
   localparam logic [7:0] CH_QUOTE  = "\"";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_DOLLAR = "$";
   localparam logic [7:0] CH_LOW_N  = "n";
   localparam logic [7:0] CH_LOW_T  = "t";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_BANG   = "!";
   localparam logic [7:0] CH_LESS   = "<";
   localparam logic [7:0] CH_MORE   = ">";
   localparam logic [7:0] CH_AMP    = "&";
   localparam logic [7:0] CH_BAR    = "|";

   // Keywords, written reversed so the first letter lands in the low byte.
   localparam logic [KW_W-1:0] KW_TEXT [NUM_KW] = '{
      KW_W'("tsaot"),   // toast
      KW_W'("fi"),      // if
      KW_W'("esle"),    // else
      KW_W'("knird"),   // drink
      KW_W'("pots"),    // stop
      KW_W'("txen"),    // next
      KW_W'("nuf"),     // fun
      KW_W'("rebos")    // sober
   };
   localparam logic [WORD_CNT_W-1:0] KW_LEN [NUM_KW] = '{
      3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [5:0] token_type;
      logic       token_end;
      logic       has_char;
      logic [7:0] text_char;
      logic       comment_error;
      logic       last_of_run;
   } rsp_payload_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   // Operators that wait one byte for a possible second character.
   function automatic logic is_holdable(logic [7:0] c);
      return (c == CH_EQUAL) || (c == CH_BANG) || (c == CH_LESS) || (c == CH_MORE) ||
             (c == CH_AMP) || (c == CH_BAR) || (c == CH_SLASH);
   endfunction

   function automatic logic [5:0] single_op(logic [7:0] c);
      logic [5:0] op;
      op = OP_NONE;
      unique case (c)
         "+":     op = TOK_PLUS;
         "-":     op = TOK_MINUS;
         "*":     op = TOK_STAR;
         "/":     op = TOK_SLASH;
         "(":     op = TOK_LPAREN;
         ")":     op = TOK_RPAREN;
         "[":     op = TOK_LBRACK;
         "]":     op = TOK_RBRACK;
         "{":     op = TOK_LBRACE;
         "}":     op = TOK_RBRACE;
         "=":     op = TOK_ASSIGN;
         "<":     op = TOK_LT;
         ">":     op = TOK_GT;
         ",":     op = TOK_COMMA;
         "!":     op = TOK_NOT;
         "&":     op = TOK_AMP;
         "|":     op = TOK_BAR;
         ";":     op = TOK_SEMI;
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

   function automatic logic [5:0] pair_op(logic [7:0] a, logic [7:0] b);
      logic [5:0] op;
      op = OP_NONE;
      if (b == CH_EQUAL) begin
         if (a == CH_EQUAL)     op = TOK_EQ;
         else if (a == CH_BANG) op = TOK_NE;
         else if (a == CH_LESS) op = TOK_LE;
         else if (a == CH_MORE) op = TOK_GE;
      end
      if ((a == CH_AMP) && (b == CH_AMP)) op = TOK_LAND;
      if ((a == CH_BAR) && (b == CH_BAR)) op = TOK_LOR;
      return op;
   endfunction

endpackage

// ===== hdl/stt_if.sv =====
// Valid/ready channel interfaces for source bytes and token results.
interface stt_req_if;
   import stt_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface stt_rsp_if;
   import stt_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/source_text_tokenizer_core.sv =====
// Byte-serial tokenizer with maximal-munch operators and a small result queue.
//
// Usage:
//  - req_if carries one source byte per transaction (in_char), or an end marker
//    (end_of_input) that flushes the pending token and returns to idle.
//  - rsp_if carries result transactions: streamed token bytes (has_char), token
//    completions (token_end with token_type), or a comment_error flag when the
//    source ends inside a block comment. last_of_run marks the final result
//    caused by one byte; a byte may cause no result at all.
//  - Each accepted byte is decoded in the cycle it is accepted; its results are
//    written into an 8-entry queue and the oldest is offered on rsp_if from the
//    next cycle on.
//  - Throughput: one byte per cycle while results drain as fast as they are
//    made. req_if.ready is high while the queue has room for three results,
//    though one byte makes at most two; a run of bytes that each yield two results
//    grows the queue by one a cycle, so the input then waits on the output port.
//  - When the receiver stalls, the queue holds results in order and req_if
//    keeps accepting until fewer than three entries are free.
//  - Reset (synchronous, active high) empties the queue and returns the scanner
//    to idle with no held operator and a cleared word prefix.
module source_text_tokenizer_core (
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req_if,
   stt_rsp_if.source rsp_if
);
   import stt_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE, M_NUMBER, M_WORD, M_TEXT, M_ESC, M_OPER, M_LINE, M_BLOCK, M_STAR
   } mode_type;

   // Scanner state
   mode_type                mode_ff,   mode_in;
   logic [7:0]              held_ff,   held_in;
   logic [PREFIX_W-1:0]     prefix_ff, prefix_in;
   logic [WORD_CNT_W-1:0]   wcount_ff, wcount_in;

   // Result queue
   rsp_payload_type         fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff,    cnt_in;

   logic                    accept, pop;
   logic [7:0]              c;
   logic                    eoi;

   rsp_payload_type         res [MAX_RESULTS];
   logic [RES_IDX_W-1:0]    nres;

   // Outcome of starting a token with the current byte
   mode_type                st_mode;
   logic [7:0]              st_held;
   logic                    st_word;
   logic                    st_emit;
   rsp_payload_type         st_res;

   logic [5:0]              wtype;

   function automatic rsp_payload_type mk(logic [5:0] ttype, logic tend, logic has,
                                          logic [7:0] ch, logic err);
      rsp_payload_type r;
      r.token_type    = ttype;
      r.token_end     = tend;
      r.has_char      = has;
      r.text_char     = ch;
      r.comment_error = err;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   // OR the byte into the prefix slot selected by the word length
   function automatic logic [PREFIX_W-1:0] add_byte(logic [PREFIX_W-1:0] prefix,
                                                     logic [WORD_CNT_W-1:0] count,
                                                     logic [7:0] ch);
      logic [PREFIX_W-1:0] r;
      r = prefix;
      for (int i = 0; i < KEYWORD_LEN; i++) begin
         if (count == WORD_CNT_W'(i)) r[8*i +: 8] = r[8*i +: 8] | ch;
      end
      return r;
   endfunction

   function automatic logic [5:0] word_type(logic [PREFIX_W-1:0] prefix,
                                            logic [WORD_CNT_W-1:0] count);
      logic [5:0] t;
      logic       hit;
      t   = TOK_WORD;
      hit = 1'b0;
      for (int k = 0; k < NUM_KW; k++) begin
         if (!hit && (KW_LEN[k] == count) && (int'(KW_LEN[k]) <= KEYWORD_LEN) &&
             (prefix[KW_W-1:0] == KW_TEXT[k])) begin
            t   = TOK_KW_BASE + 6'(k);
            hit = 1'b1;
         end
      end
      return t;
   endfunction

   assign c      = req_if.payload.in_char;
   assign eoi    = req_if.payload.end_of_input;
   assign accept = req_if.valid && req_if.ready;
   assign pop    = rsp_if.valid && rsp_if.ready;

   // Room for a full burst of results from one byte
   assign req_if.ready   = (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
   assign rsp_if.valid   = (cnt_ff != '0);
   assign rsp_if.payload = fifo_ff[rd_ptr_ff];

   assign wtype = word_type(prefix_ff, wcount_ff);

   // Token start decode
   always_comb begin
      st_mode = M_IDLE;
      st_held = '0;
      st_word = 1'b0;
      st_emit = 1'b0;
      st_res  = mk(TOK_NUMBER, 1'b0, 1'b0, '0, 1'b0);
      if (is_digit(c)) begin
         st_mode = M_NUMBER;
         st_emit = 1'b1;
         st_res  = mk(TOK_NUMBER, 1'b0, 1'b1, c, 1'b0);
      end else if (is_alpha(c)) begin
         st_mode = M_WORD;
         st_word = 1'b1;
         st_emit = 1'b1;
         st_res  = mk(TOK_NUMBER, 1'b0, 1'b1, c, 1'b0);
      end else if (c == CH_QUOTE) begin
         st_mode = M_TEXT;
      end else if (is_holdable(c)) begin
         st_mode = M_OPER;
         st_held = c;
      end else if (single_op(c) != OP_NONE) begin
         st_emit = 1'b1;
         st_res  = mk(single_op(c), 1'b1, 1'b0, '0, 1'b0);
      end
   end

   // Scanner: next state and the results of this byte
   always_comb begin
      logic       do_start;
      logic [5:0] op;
      mode_in   = mode_ff;
      held_in   = held_ff;
      prefix_in = prefix_ff;
      wcount_in = wcount_ff;
      do_start  = 1'b0;
      op        = OP_NONE;
      nres      = '0;
      for (int k = 0; k < MAX_RESULTS; k++) res[k] = mk(TOK_NUMBER, 1'b0, 1'b0, '0, 1'b0);

      if (eoi) begin
         // flush whatever token is open
         unique case (mode_ff)
            M_NUMBER: begin
               res[nres] = mk(TOK_NUMBER, 1'b1, 1'b0, '0, 1'b0);
               nres      = nres + 1'b1;
            end
            M_WORD: begin
               res[nres] = mk(wtype, 1'b1, 1'b0, '0, 1'b0);
               nres      = nres + 1'b1;
            end
            M_ESC: begin
               res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, CH_BSLASH, 1'b0);
               nres      = nres + 1'b1;
               res[nres] = mk(TOK_TEXT, 1'b1, 1'b0, '0, 1'b0);
               nres      = nres + 1'b1;
            end
            M_TEXT: begin
               res[nres] = mk(TOK_TEXT, 1'b1, 1'b0, '0, 1'b0);
               nres      = nres + 1'b1;
            end
            M_OPER: begin
               op = single_op(held_ff);
               if (op != OP_NONE) begin
                  res[nres] = mk(op, 1'b1, 1'b0, '0, 1'b0);
                  nres      = nres + 1'b1;
               end
            end
            M_BLOCK, M_STAR: begin
               res[nres] = mk(TOK_NUMBER, 1'b0, 1'b0, '0, 1'b1);
               nres      = nres + 1'b1;
            end
            default: ;
         endcase
         mode_in = M_IDLE;
         held_in = '0;
      end else begin
         unique case (mode_ff)
            M_NUMBER: begin
               if (is_digit(c)) begin
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, c, 1'b0);
                  nres      = nres + 1'b1;
               end else begin
                  res[nres] = mk(TOK_NUMBER, 1'b1, 1'b0, '0, 1'b0);
                  nres      = nres + 1'b1;
                  do_start  = 1'b1;
               end
            end
            M_WORD: begin
               if (is_digit(c) || is_alpha(c) || (c == CH_UNDER) || (c == CH_DOLLAR)) begin
                  prefix_in = add_byte(prefix_ff, wcount_ff, c);
                  if (wcount_ff != WORD_CNT_MAX) wcount_in = wcount_ff + 1'b1;
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, c, 1'b0);
                  nres      = nres + 1'b1;
               end else begin
                  res[nres] = mk(wtype, 1'b1, 1'b0, '0, 1'b0);
                  nres      = nres + 1'b1;
                  do_start  = 1'b1;
               end
            end
            M_TEXT: begin
               if (c == CH_BSLASH) begin
                  mode_in = M_ESC;
               end else if (c == CH_QUOTE) begin
                  res[nres] = mk(TOK_TEXT, 1'b1, 1'b0, '0, 1'b0);
                  nres      = nres + 1'b1;
                  mode_in   = M_IDLE;
               end else begin
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, c, 1'b0);
                  nres      = nres + 1'b1;
               end
            end
            M_ESC: begin
               if (c == CH_QUOTE) begin
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, CH_QUOTE, 1'b0);
                  nres      = nres + 1'b1;
               end else if (c == CH_LOW_N) begin
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, CH_LF, 1'b0);
                  nres      = nres + 1'b1;
               end else if (c == CH_LOW_T) begin
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, CH_TAB, 1'b0);
                  nres      = nres + 1'b1;
               end else begin
                  // unknown escape: keep both bytes
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, CH_BSLASH, 1'b0);
                  nres      = nres + 1'b1;
                  res[nres] = mk(TOK_NUMBER, 1'b0, 1'b1, c, 1'b0);
                  nres      = nres + 1'b1;
               end
               mode_in = M_TEXT;
            end
            M_OPER: begin
               if ((held_ff == CH_SLASH) && (c == CH_SLASH)) begin
                  mode_in = M_LINE;
                  held_in = '0;
               end else if ((held_ff == CH_SLASH) && (c == CH_STAR)) begin
                  mode_in = M_BLOCK;
                  held_in = '0;
               end else if (pair_op(held_ff, c) != OP_NONE) begin
                  res[nres] = mk(pair_op(held_ff, c), 1'b1, 1'b0, '0, 1'b0);
                  nres      = nres + 1'b1;
                  mode_in   = M_IDLE;
                  held_in   = '0;
               end else begin
                  op = single_op(held_ff);
                  if (op != OP_NONE) begin
                     res[nres] = mk(op, 1'b1, 1'b0, '0, 1'b0);
                     nres      = nres + 1'b1;
                  end
                  do_start = 1'b1;
               end
            end
            M_LINE: begin
               if ((c == CH_LF) || (c == CH_CR)) mode_in = M_IDLE;
            end
            M_BLOCK: begin
               if (c == CH_STAR) mode_in = M_STAR;
            end
            M_STAR: begin
               if (c == CH_SLASH)     mode_in = M_IDLE;
               else if (c != CH_STAR) mode_in = M_BLOCK;
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         if (do_start) begin
            mode_in = st_mode;
            held_in = st_held;
            if (st_word) begin
               prefix_in = add_byte('0, '0, c);
               wcount_in = WORD_CNT_W'(1);
            end
            if (st_emit) begin
               res[nres] = st_res;
               nres      = nres + 1'b1;
            end
         end
      end

      if (nres != '0) res[nres - 1'b1].last_of_run = 1'b1;
   end

   // Queue bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(nres);
         cnt_in    = cnt_in + FIFO_CNT_W'(nres);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         cnt_in    = cnt_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         held_ff   <= '0;
         prefix_ff <= '0;
         wcount_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            held_ff   <= held_in;
            prefix_ff <= prefix_in;
            wcount_ff <= wcount_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage: results of one byte land in consecutive slots
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (accept && (RES_IDX_W'(k) < nres)) begin
            fifo_ff[wr_ptr_ff + FIFO_PTR_W'(k)] <= res[k];
         end
      end
   end

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_held_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_OPER) == (held_ff != '0))
      else $error("held operator out of step with scan mode");

   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && eoi) |=> (mode_ff == M_IDLE) && (held_ff == '0))
      else $error("end of input did not return scanner to idle");

endmodule
